// ===== rtl/framed_packet_checksum_deframer_defines.svh =====
// Assertion macros used by the port-level checker of the deframer.
`ifndef FRAMED_PACKET_CHECKSUM_DEFRAMER_DEFINES_SVH
`define FRAMED_PACKET_CHECKSUM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FPCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fpcd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fpcd assertion failed");

`endif

// ===== rtl/fpcd_pkg.sv =====
// Types, codes and constants of the framed packet checksum deframer.
package fpcd_pkg;

	localparam int LENGTH_BITS = 16;
	localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 32'd1);

	localparam int TDATA_W = 40;
	localparam int TUSER_W = 3;

	localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] CFG_MAX_PAYLOAD   = 2'd2;

	localparam logic [7:0]  RST_HEADER_FIRST  = 8'h75;
	localparam logic [7:0]  RST_HEADER_SECOND = 8'h65;
	localparam logic [15:0] RST_MAX_PAYLOAD   = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_HUNT1, PH_HUNT2, PH_DESC, PH_LENHI, PH_LENLO, PH_PAYLOAD, PH_CK1, PH_CK2
	} phase_t;

	typedef enum logic [2:0] {
		KIND_DISCARD = 3'd0,
		KIND_HEADER  = 3'd1,
		KIND_DESC    = 3'd2,
		KIND_LENGTH  = 3'd3,
		KIND_PAYLOAD = 3'd4,
		KIND_CHECK   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_PROGRESS = 2'd0,
		ST_OK       = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_TOOLONG  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  header_first;
		logic [7:0]  header_second;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [15:0] length;
		logic [7:0]  descriptor;
		status_t     status;
		logic        frame_end;
		kind_t       kind;
		logic [7:0]  data;
	} result_t;

endpackage

// ===== rtl/fpcd_parser.sv =====
// Frame state machine with Fletcher-style sums taken modulo 256; produces the result for one byte.
module fpcd_parser
	import fpcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] in_byte,
	input  cfg_t       cfg,
	output result_t    result
);

	phase_t      phase_q, phase_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] declared_q, declared_d;
	logic [7:0]  sum1_q, sum1_d;
	logic [7:0]  sum2_q, sum2_d;
	logic [7:0]  desc_q, desc_d;
	logic        ck1_ok_q, ck1_ok_d;
	logic [7:0]  acc1, acc2;
	logic [15:0] len_lo;

	assign acc1   = sum1_q + in_byte;
	assign acc2   = sum2_q + acc1;
	assign len_lo = (declared_q | {8'd0, in_byte}) & LEN_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT1;
			remaining_q <= '0;
			declared_q  <= '0;
			sum1_q      <= '0;
			sum2_q      <= '0;
			desc_q      <= '0;
			ck1_ok_q    <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			declared_q  <= declared_d;
			sum1_q      <= sum1_d;
			sum2_q      <= sum2_d;
			desc_q      <= desc_d;
			ck1_ok_q    <= ck1_ok_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		declared_d  = declared_q;
		sum1_d      = sum1_q;
		sum2_d      = sum2_q;
		desc_d      = desc_q;
		ck1_ok_d    = ck1_ok_q;
		result.data       = in_byte;
		result.kind       = KIND_DISCARD;
		result.frame_end  = 1'b0;
		result.status     = ST_PROGRESS;
		result.descriptor = '0;
		result.length     = '0;
		unique case (phase_q)
			PH_HUNT1: begin
				if (in_byte == cfg.header_first) begin
					result.kind = KIND_HEADER;
					sum1_d      = in_byte;
					sum2_d      = in_byte;
					phase_d     = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				if (in_byte == cfg.header_second) begin
					result.kind = KIND_HEADER;
					sum1_d      = acc1;
					sum2_d      = acc2;
					phase_d     = PH_DESC;
				end else if (in_byte == cfg.header_first) begin
					result.kind = KIND_HEADER;
					sum1_d      = in_byte;
					sum2_d      = in_byte;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_DESC: begin
				result.kind = KIND_DESC;
				desc_d      = in_byte;
				sum1_d      = acc1;
				sum2_d      = acc2;
				phase_d     = PH_LENHI;
			end
			PH_LENHI: begin
				result.kind = KIND_LENGTH;
				declared_d  = {in_byte, 8'd0};
				sum1_d      = acc1;
				sum2_d      = acc2;
				phase_d     = PH_LENLO;
			end
			PH_LENLO: begin
				result.kind = KIND_LENGTH;
				declared_d  = len_lo;
				sum1_d      = acc1;
				sum2_d      = acc2;
				if (len_lo > cfg.max_payload) begin
					result.frame_end  = 1'b1;
					result.status     = ST_TOOLONG;
					result.descriptor = desc_q;
					result.length     = len_lo;
					phase_d           = PH_HUNT1;
				end else if (len_lo == 16'd0) begin
					phase_d = PH_CK1;
				end else begin
					remaining_d = len_lo;
					phase_d     = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				result.kind = KIND_PAYLOAD;
				sum1_d      = acc1;
				sum2_d      = acc2;
				remaining_d = remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					phase_d = PH_CK1;
				end
			end
			PH_CK1: begin
				result.kind = KIND_CHECK;
				ck1_ok_d    = (in_byte == sum1_q);
				phase_d     = PH_CK2;
			end
			PH_CK2: begin
				result.kind       = KIND_CHECK;
				result.frame_end  = 1'b1;
				result.status     = (ck1_ok_q && in_byte == sum2_q) ? ST_OK : ST_MISMATCH;
				result.descriptor = desc_q;
				result.length     = declared_q;
				phase_d           = PH_HUNT1;
			end
			default: begin
				phase_d = PH_HUNT1;
			end
		endcase
	end

endmodule

// ===== rtl/framed_packet_checksum_deframer.sv =====
// Top level of the framed packet checksum deframer.
// Each accepted byte passes an input register and then a result register on its way out.
// Throughput: one byte per cycle, sustained while the output side takes results.
// The frame state machine and both 8-bit sums update once per byte, as it advances.
// Reset (arst_n low, asynchronous): hunting for the first header byte, sums cleared,
// no result held, header bytes 0x75/0x65 and maximum payload 65535.
module framed_packet_checksum_deframer
	import fpcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] in_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // [7:0] out_byte, [9:8] frame_status,
	                                     // [17:10] frame_descriptor,
	                                     // [33:18] frame_payload_length, rest zero
	output logic [TUSER_W-1:0] m_tuser,  // [2:0] byte_kind
	output logic               m_tlast,  // frame_end
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       m_valid_q;
	result_t    res_q;
	result_t    res;
	logic       advance;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= RST_HEADER_FIRST;
			cfg_q.header_second <= RST_HEADER_SECOND;
			cfg_q.max_payload   <= RST_MAX_PAYLOAD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data[7:0];
				CFG_HEADER_SECOND: cfg_q.header_second <= cfg_data[7:0];
				CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!m_valid_q || m_tready) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	fpcd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.in_byte (byte_s1),
		.cfg     (cfg_q),
		.result  (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_q.length, res_q.descriptor, res_q.status, res_q.data};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.frame_end;

endmodule

// ===== rtl/fpcd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
`include "framed_packet_checksum_deframer_defines.svh"

module fpcd_checker
	import fpcd_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [TUSER_W-1:0] m_tuser,
	input logic               m_tlast
);

	`FPCD_ASSERT_NEXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	`FPCD_ASSERT_IMPLY(a_end_kind, clk, arst_n, m_tvalid && m_tlast, (m_tuser == KIND_LENGTH && m_tdata[9:8] == ST_TOOLONG) || (m_tuser == KIND_CHECK && (m_tdata[9:8] == ST_OK || m_tdata[9:8] == ST_MISMATCH)))
	`FPCD_ASSERT_IMPLY(a_mid_clear, clk, arst_n, m_tvalid && !m_tlast, m_tdata[9:8] == ST_PROGRESS && m_tdata[TDATA_W-1:10] == '0)

endmodule

bind framed_packet_checksum_deframer fpcd_checker u_fpcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== sim/tb_framed_packet_checksum_deframer.sv =====
// Testbench of the framed packet checksum deframer against a deframing predictor.
module tb_framed_packet_checksum_deframer
	import fpcd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0] m_tuser;
	logic               m_tlast;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = CFG_HEADER_FIRST;
	logic [15:0]        cfg_data = 16'h0000;

	framed_packet_checksum_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	cfg_t        shadow_cfg;
	phase_t      frame_phase;
	logic [15:0] bytes_left;
	logic [15:0] frame_len;
	logic [7:0]  fletcher_a;
	logic [7:0]  fletcher_b;
	logic [7:0]  frame_desc;
	logic        ck1_matched;

	result_t     predicted_bytes[$];
	int          fail_cnt = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_token = 0;
	int          cycle_cnt = 0;

	task automatic fold_byte(input logic [7:0] b);
		fletcher_a = fletcher_a + b;
		fletcher_b = fletcher_b + fletcher_a;
	endtask

	task automatic open_frame(input logic [7:0] b);
		fletcher_a = 8'h00;
		fletcher_b = 8'h00;
		fold_byte(b);
		frame_phase = PH_HUNT2;
	endtask

	task automatic deframe_byte(input logic [7:0] b, output result_t r);
		r = '0;
		r.data = b;
		r.kind = KIND_DISCARD;
		r.status = ST_PROGRESS;
		r.frame_end = 1'b0;
		case (frame_phase)
			PH_HUNT1: begin
				if (b == shadow_cfg.header_first) begin
					r.kind = KIND_HEADER;
					open_frame(b);
				end
			end
			PH_HUNT2: begin
				if (b == shadow_cfg.header_second) begin
					r.kind = KIND_HEADER;
					fold_byte(b);
					frame_phase = PH_DESC;
				end else if (b == shadow_cfg.header_first) begin
					r.kind = KIND_HEADER;
					open_frame(b);
				end else begin
					frame_phase = PH_HUNT1;
				end
			end
			PH_DESC: begin
				r.kind = KIND_DESC;
				frame_desc = b;
				fold_byte(b);
				frame_phase = PH_LENHI;
			end
			PH_LENHI: begin
				r.kind = KIND_LENGTH;
				frame_len = {b, 8'h00};
				fold_byte(b);
				frame_phase = PH_LENLO;
			end
			PH_LENLO: begin
				r.kind = KIND_LENGTH;
				frame_len = (frame_len | {8'h00, b}) & LEN_MASK;
				fold_byte(b);
				if (frame_len > shadow_cfg.max_payload) begin
					r.frame_end = 1'b1;
					r.status = ST_TOOLONG;
					frame_phase = PH_HUNT1;
				end else if (frame_len == 16'h0000) begin
					frame_phase = PH_CK1;
				end else begin
					bytes_left = frame_len;
					frame_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				fold_byte(b);
				bytes_left = bytes_left - 16'd1;
				if (bytes_left == 16'h0000)
					frame_phase = PH_CK1;
			end
			PH_CK1: begin
				r.kind = KIND_CHECK;
				ck1_matched = (b == fletcher_a);
				frame_phase = PH_CK2;
			end
			default: begin
				r.kind = KIND_CHECK;
				r.frame_end = 1'b1;
				r.status = (ck1_matched && b == fletcher_b) ? ST_OK : ST_MISMATCH;
				frame_phase = PH_HUNT1;
			end
		endcase
		if (r.frame_end) begin
			r.descriptor = frame_desc;
			r.length = frame_len;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		deframe_byte(b, r);
		predicted_bytes = {predicted_bytes, r};
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (predicted_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_HEADER_FIRST:  shadow_cfg.header_first = val[7:0];
			CFG_HEADER_SECOND: shadow_cfg.header_second = val[7:0];
			CFG_MAX_PAYLOAD:   shadow_cfg.max_payload = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] hf, input logic [7:0] hs,
			input logic [15:0] max_len);
		drain();
		write_reg(CFG_HEADER_FIRST, {8'h00, hf});
		write_reg(CFG_HEADER_SECOND, {8'h00, hs});
		write_reg(CFG_MAX_PAYLOAD, max_len);
	endtask

	// fault: 0 clean, 1 first check byte wrong, 2 second check byte wrong
	// fill: payload byte value, or negative for random payload
	task automatic send_frame(input logic [7:0] desc, input int len, input int fault,
			input int fill);
		logic [7:0] frame_bytes[$];
		logic [7:0] sa;
		logic [7:0] sb;
		logic [15:0] lv;
		lv = len[15:0];
		frame_bytes = {shadow_cfg.header_first, shadow_cfg.header_second, desc,
			lv[15:8], lv[7:0]};
		if (lv <= shadow_cfg.max_payload) begin
			for (int i = 0; i < len; i++)
				frame_bytes = {frame_bytes,
					(fill < 0 ? 8'($urandom_range(255)) : 8'(fill))};
			sa = 8'h00;
			sb = 8'h00;
			foreach (frame_bytes[i]) begin
				sa = sa + frame_bytes[i];
				sb = sb + sa;
			end
			if (fault == 1)
				sa = sa ^ 8'($urandom_range(255, 1));
			if (fault == 2)
				sb = sb ^ 8'($urandom_range(255, 1));
			frame_bytes = {frame_bytes, sa, sb};
		end
		foreach (frame_bytes[i])
			push_byte(frame_bytes[i]);
	endtask

	task automatic random_traffic(input int n_items);
		int sent;
		int pick;
		int len;
		int fault;
		int m;
		logic [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			m = int'(shadow_cfg.max_payload);
			if (pick < 70 || (pick < 80 && m == 65535)) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
				fault = $urandom_range(9);
				fault = (fault == 0) ? 1 : (fault == 1) ? 2 : 0;
				send_frame(8'($urandom_range(255)), len, fault, -1);
				sent += (len > m) ? 5 : 7 + len;
			end else if (pick < 80) begin
				len = m + 1 + $urandom_range(65534 - m);
				send_frame(8'($urandom_range(255)), len, 0, -1);
				sent += 5;
			end else if (pick < 90) begin
				push_byte(shadow_cfg.header_first);
				do b = 8'($urandom_range(255));
				while (b == shadow_cfg.header_first || b == shadow_cfg.header_second);
				push_byte(b);
				sent += 2;
			end else begin
				repeat ($urandom_range(4, 1)) begin
					b = 8'($urandom_range(255));
					if (b == shadow_cfg.header_first)
						b = b ^ 8'h01;
					push_byte(b);
					sent++;
				end
			end
		end
	endtask

	task automatic test_special_cases();
		idle_pct = 0;
		stall_pct = 0;
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(RST_HEADER_FIRST);
		push_byte(8'h00);
		push_byte(RST_HEADER_FIRST);
		send_frame(8'hFF, 0, 0, -1);
		send_frame(8'h00, 1, 2, 8'hFF);
		send_frame(8'h5A, 1, 1, 8'h00);
	endtask

	task automatic test_length_limit();
		set_config(8'h00, 8'hFF, 16'h0000);
		send_frame(8'hA5, 16'h0001, 0, -1);
		send_frame(8'h3C, 0, 0, -1);
		send_frame(8'hC3, 16'hFFFF, 0, -1);
	endtask

	task automatic test_random_traffic();
		drain();
		idle_pct = 0;
		stall_pct = 0;
		random_traffic(230);
		set_config(8'hFF, 8'h00, 16'hFFFF);
		idle_pct = 79;
		stall_pct = 0;
		random_traffic(230);
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(40)));
		idle_pct = 0;
		stall_pct = 79;
		random_traffic(230);
		set_config(8'h96, 8'h96, 16'($urandom_range(65535)));
		idle_pct = 37;
		stall_pct = 37;
		random_traffic(230);
	endtask

	task automatic test_backpressure();
		set_config(RST_HEADER_FIRST, RST_HEADER_SECOND, 16'd24);
		idle_pct = 0;
		stall_pct = 0;
		hold_token++;
		random_traffic(100);
	endtask

	always @(posedge clk) begin : receiver
		int hold_seen;
		int hold_left;
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic flag_mismatch(input string what, input logic [39:0] want,
			input logic [39:0] got);
		fail_cnt++;
		$display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_bytes.size() == 0) begin
				flag_mismatch("unexpected result", 40'h0, m_tdata);
			end else begin
				want = predicted_bytes.pop_front();
				if (m_tdata[7:0] !== want.data)
					flag_mismatch("out_byte", 40'(want.data), 40'(m_tdata[7:0]));
				if (m_tuser[2:0] !== want.kind)
					flag_mismatch("byte_kind", 40'(want.kind), 40'(m_tuser[2:0]));
				if (m_tlast !== want.frame_end)
					flag_mismatch("frame_end", 40'(want.frame_end), 40'(m_tlast));
				if (m_tdata[9:8] !== want.status)
					flag_mismatch("frame_status", 40'(want.status), 40'(m_tdata[9:8]));
				if (m_tdata[17:10] !== want.descriptor)
					flag_mismatch("frame_descriptor", 40'(want.descriptor),
						40'(m_tdata[17:10]));
				if (m_tdata[33:18] !== want.length)
					flag_mismatch("frame_payload_length", 40'(want.length),
						40'(m_tdata[33:18]));
				if (m_tdata[TDATA_W-1:34] !== '0)
					flag_mismatch("tdata padding", 40'h0, 40'(m_tdata[TDATA_W-1:34]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		shadow_cfg = {RST_HEADER_FIRST, RST_HEADER_SECOND, RST_MAX_PAYLOAD};
		frame_phase = PH_HUNT1;
		bytes_left = 16'h0000;
		frame_len = 16'h0000;
		fletcher_a = 8'h00;
		fletcher_b = 8'h00;
		frame_desc = 8'h00;
		ck1_matched = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_length_limit();
		test_random_traffic();
		test_backpressure();
		drain();
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
